### src/mdk_pkg.sv
// ----------------------------------------------------------------------------
// mdk_pkg
// Shared types, constants and the digit pattern table for the Morse keyer.
// ----------------------------------------------------------------------------
package mdk_pkg;

    localparam logic [7:0] CharZero = 8'h30;
    localparam logic [7:0] CharNine = 8'h39;

    localparam int SegCount = 11;
    localparam int SegWidth = $clog2(SegCount);
    localparam logic [SegWidth-1:0] SegLast = SegWidth'(SegCount - 1);

    localparam logic [1:0] UnitsShort = 2'd1;
    localparam logic [1:0] UnitsLong  = 2'd3;

    typedef logic [4:0]          t_pat;
    typedef logic [SegWidth-1:0] t_seg_idx;

    // Handoff from the character classifier to the segment sequencer.
    typedef struct packed {
        logic vld;
        t_pat pat;
    } t_job;

    // Bit 4 is the first symbol; a set bit is a dash.
    function automatic t_pat digit_pattern(input logic [3:0] digit);
        t_pat pat;
        unique case (digit)
            4'd0:    pat = 5'b11111;
            4'd1:    pat = 5'b01111;
            4'd2:    pat = 5'b00111;
            4'd3:    pat = 5'b00011;
            4'd4:    pat = 5'b00001;
            4'd5:    pat = 5'b00000;
            4'd6:    pat = 5'b10000;
            4'd7:    pat = 5'b11000;
            4'd8:    pat = 5'b11100;
            4'd9:    pat = 5'b11110;
            default: pat = 5'b00000;
        endcase
        return pat;
    endfunction

endpackage

### src/mdk_classify.sv
// ----------------------------------------------------------------------------
// mdk_classify
// Holds the halt flag and turns an accepted character into a keying job.
// ----------------------------------------------------------------------------
module mdk_classify
    import mdk_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_character,
    input  logic       i_message_start,
    output t_job       o_job
);

    logic r_halted;
    logic n_halted;
    logic eff_halted;
    logic is_digit;

    assign is_digit   = (i_character >= CharZero) && (i_character <= CharNine);
    // A message start clears the flag before the character itself is judged.
    assign eff_halted = r_halted && !i_message_start;

    always_comb begin
        n_halted = r_halted;
        if (i_accept) begin
            n_halted = eff_halted || !is_digit;
        end
    end

    assign o_job.vld = i_accept && !eff_halted && is_digit;
    assign o_job.pat = digit_pattern(i_character[3:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_halted <= 1'b0;
        end else begin
            r_halted <= n_halted;
        end
    end

endmodule

### src/mdk_segment.sv
// ----------------------------------------------------------------------------
// mdk_segment
// Job register, segment counter and output register of the Morse keyer.
// ----------------------------------------------------------------------------
module mdk_segment
    import mdk_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_job,
    input  logic       i_stall,
    output logic       o_busy,
    output logic       o_valid,
    output logic       o_led_on,
    output logic [1:0] o_units,
    output logic       o_last_segment
);

    logic     r_job_vld;
    t_pat     r_pat;
    t_seg_idx r_seg;
    logic     r_out_vld;
    logic     r_led_on;
    logic [1:0] r_units;
    logic     r_last;

    logic       out_load;
    logic       seg_take;
    logic       seg_is_last;
    logic [2:0] sym_idx;
    logic       sym_dash;
    logic       n_led_on;
    logic [1:0] n_units;

    assign out_load    = !r_out_vld || !i_stall;
    assign seg_take    = r_job_vld && out_load;
    assign seg_is_last = (r_seg == SegLast);

    // The slot frees in the same cycle its final gap moves to the output.
    assign o_busy = r_job_vld && !(seg_take && seg_is_last);

    // Even segments below the last are symbols, odd ones the dark unit after each symbol.
    assign sym_idx = 3'd4 - r_seg[3:1];

    always_comb begin
        unique case (sym_idx)
            3'd0:    sym_dash = r_pat[0];
            3'd1:    sym_dash = r_pat[1];
            3'd2:    sym_dash = r_pat[2];
            3'd3:    sym_dash = r_pat[3];
            3'd4:    sym_dash = r_pat[4];
            default: sym_dash = 1'b0;
        endcase
    end

    always_comb begin
        if (seg_is_last) begin
            n_led_on = 1'b0;
            n_units  = UnitsLong;
        end else if (!r_seg[0]) begin
            n_led_on = 1'b1;
            n_units  = sym_dash ? UnitsLong : UnitsShort;
        end else begin
            n_led_on = 1'b0;
            n_units  = UnitsShort;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_vld <= 1'b0;
            r_seg     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_job.vld) begin
                r_job_vld <= 1'b1;
                r_seg     <= '0;
            end else if (seg_take) begin
                r_job_vld <= !seg_is_last;
                r_seg     <= seg_is_last ? '0 : r_seg + t_seg_idx'(1);
            end
            if (out_load) begin
                r_out_vld <= r_job_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_job.vld) begin
            r_pat <= i_job.pat;
        end
        if (seg_take) begin
            r_led_on <= n_led_on;
            r_units  <= n_units;
            r_last   <= seg_is_last;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_led_on       = r_led_on;
    assign o_units        = r_units;
    assign o_last_segment = r_last;

endmodule

### src/morse_digit_keyer.sv
// ----------------------------------------------------------------------------
// morse_digit_keyer
// Keys decimal digits of a message as Morse LED segments in dot units.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake           Payload
// input    in         i_valid / o_stall   i_character, i_message_start
// result   out        o_valid / i_stall   o_led_on, o_units, o_last_segment
//
// A digit yields 11 segments, one per cycle from the segment counter while
// the result side does not stall; a non-digit or halted character yields
// nothing and leaves the block free. The next character is taken in the
// cycle the final gap segment enters the output register.
// Reset is synchronous and clears the halt flag, the job slot and o_valid.
// A stall on a pending result holds the output register and the counter.
// ----------------------------------------------------------------------------
module morse_digit_keyer
    import mdk_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_character,
    input  logic       i_message_start,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_led_on,
    output logic [1:0] o_units,
    output logic       o_last_segment
);

    logic in_accept;
    logic seg_busy;
    t_job job;

    assign o_stall   = seg_busy;
    assign in_accept = i_valid && !seg_busy;

    mdk_classify u_classify (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_character     (i_character),
        .i_message_start (i_message_start),
        .o_job           (job)
    );

    mdk_segment u_segment (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (job),
        .i_stall        (i_stall),
        .o_busy         (seg_busy),
        .o_valid        (o_valid),
        .o_led_on       (o_led_on),
        .o_units        (o_units),
        .o_last_segment (o_last_segment)
    );

endmodule

### src/mdk_checker.sv
// ----------------------------------------------------------------------------
// mdk_checker
// Port-level checks of the Morse keyer, bound to the top level.
// ----------------------------------------------------------------------------
module mdk_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_led_on,
    input logic [1:0] o_units,
    input logic       o_last_segment
);

    // A stalled result transaction holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_led_on) && $stable(o_units)
            && $stable(o_last_segment))
        else $error("stalled result changed");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // The closing gap of a digit is a dark 3-unit segment.
    a_gap_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_segment |-> !o_led_on && o_units == 2'd3)
        else $error("bad closing gap");

    // A lit symbol is a dot or a dash.
    a_lit_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_led_on |-> o_units == 2'd1 || o_units == 2'd3)
        else $error("bad symbol length");

    // The gap after each symbol is one dark unit.
    a_dark_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_led_on && !o_last_segment |-> o_units == 2'd1)
        else $error("bad inter-symbol gap");

endmodule

bind morse_digit_keyer mdk_checker u_mdk_checker (.*);
